FILE: sv/battery_level_monitor_top_defines.svh
// Assertion macros shared by the battery level monitor RTL.
`ifndef BATTERY_LEVEL_MONITOR_TOP_DEFINES_SVH
`define BATTERY_LEVEL_MONITOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define BLM_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define BLM_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: sv/blm_pkg.sv
// Shared constants, types and command/status structs of the battery level monitor.
package blm_pkg;

   // Field widths
   localparam int SAMPLE_BITS = 12;
   localparam int CNT_W       = 8;
   localparam int MV_W        = 14;
   localparam int PCT_W       = 7;
   localparam int CMP_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 14;

   // Batch sum never wraps: 255 samples of SAMPLE_BITS each
   localparam int SUM_W       = SAMPLE_BITS + CNT_W;
   // Divisor for the average: 1..255
   localparam int AVG_DIV_W   = CNT_W + 1;
   // Percent numerator: (mv - empty) * 100
   localparam int PCT_NUM_W   = MV_W + PCT_W;
   // Shared divider width covers sum, percent numerator and full << 8
   localparam int CMP_NUM_W   = MV_W + 8;
   localparam int DIV_W       = (SUM_W > CMP_NUM_W) ? SUM_W : CMP_NUM_W;
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
   localparam int PROD_W      = SUM_W + MV_W;

   // Constants
   localparam logic [MV_W-1:0]  MV_SCALE       = MV_W'(13006);
   localparam logic [PCT_W-1:0] PERCENT_FULL   = PCT_W'(100);
   localparam logic [CMP_W-1:0] CMP_SATURATED  = '1;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_COUNT     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FULL_MILLIVOLTS  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_EMPTY_MILLIVOLTS = CSR_IDX_W'(2);
   localparam logic [CNT_W-1:0]     SAMPLE_COUNT_RESET   = CNT_W'(10);
   localparam logic [MV_W-1:0]      FULL_MV_RESET        = MV_W'(12600);
   localparam logic [MV_W-1:0]      EMPTY_MV_RESET       = MV_W'(9900);

   // Divider operand selection
   typedef enum logic [1:0] {
      SEL_AVG = 2'd0,
      SEL_PCT = 2'd1,
      SEL_CMP = 2'd2
   } div_sel_type;

   // Controller states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_AVG    = 7'b0000010,
      ST_SCALE  = 7'b0000100,
      ST_PCT_GO = 7'b0001000,
      ST_PCT    = 7'b0010000,
      ST_CMP    = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic        accept;
      logic        div_start;
      div_sel_type div_sel;
      logic        avg_load;
      logic        mv_load;
      logic        pct_load;
      logic        cmp_load;
      logic        out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic batch_done;
      logic div_done;
   } status_type;

endpackage

FILE: sv/blm_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle, shared by all divisions.
module blm_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [blm_pkg::DIV_W-1:0]      dividend,
   input  logic [blm_pkg::MV_W-1:0]       divisor,
   output logic                           done,
   output logic [blm_pkg::DIV_W-1:0]      quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [blm_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [blm_pkg::MV_W-1:0]          rem_ff, rem_in;
   logic [blm_pkg::DIV_W-1:0]         quo_ff, quo_in;
   logic [blm_pkg::MV_W-1:0]          dvs_ff, dvs_in;
   logic [blm_pkg::MV_W:0]            shifted;
   logic                              ge;

   // One shift-compare-subtract step
   always_comb begin
      shifted = {rem_ff, quo_ff[blm_pkg::DIV_W-1]};
      ge      = (shifted >= {1'b0, dvs_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = blm_pkg::DIV_CNT_W'(blm_pkg::DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? blm_pkg::MV_W'(shifted - {1'b0, dvs_ff})
                     : shifted[blm_pkg::MV_W-1:0];
         quo_in = {quo_ff[blm_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == blm_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/blm_datapath.sv
// Datapath: config registers, batch accumulator, scaling, divider and result registers.
module blm_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  blm_pkg::cmd_type                   cmd,
   output blm_pkg::status_type                status,
   input  logic                               csr_wr_en,
   input  logic [blm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [blm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [blm_pkg::SAMPLE_BITS-1:0]    req_sample,
   output logic [blm_pkg::MV_W-1:0]           rsp_battery_millivolts,
   output logic [blm_pkg::PCT_W-1:0]          rsp_charge_percent,
   output logic [blm_pkg::CMP_W-1:0]          rsp_drive_compensation
);

   logic [blm_pkg::CNT_W-1:0]      count_ff;
   logic [blm_pkg::MV_W-1:0]       full_ff;
   logic [blm_pkg::MV_W-1:0]       empty_ff;
   logic [blm_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [blm_pkg::CNT_W-1:0]      taken_ff, taken_in;
   logic [blm_pkg::CNT_W-1:0]      need;
   logic [blm_pkg::AVG_DIV_W-1:0]  avg_div;
   logic                           batch_done;
   logic [blm_pkg::SUM_W-1:0]      avg_ff;
   logic [blm_pkg::PROD_W-1:0]     prod;
   logic [blm_pkg::MV_W-1:0]       mv_ff;
   logic [blm_pkg::PCT_W-1:0]      pct_ff, pct_in;
   logic [blm_pkg::CMP_W-1:0]      cmp_ff, cmp_in;
   logic [blm_pkg::MV_W-1:0]       rsp_mv_ff;
   logic [blm_pkg::PCT_W-1:0]      rsp_pct_ff;
   logic [blm_pkg::CMP_W-1:0]      rsp_cmp_ff;
   logic [blm_pkg::MV_W-1:0]       span;
   logic [blm_pkg::PCT_NUM_W-1:0]  pct_num;
   logic                           pct_zero;
   logic [blm_pkg::DIV_W-1:0]      div_dividend;
   logic [blm_pkg::MV_W-1:0]       div_divisor;
   logic                           div_done;
   logic [blm_pkg::DIV_W-1:0]      div_quotient;

   // Configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= blm_pkg::SAMPLE_COUNT_RESET;
         full_ff  <= blm_pkg::FULL_MV_RESET;
         empty_ff <= blm_pkg::EMPTY_MV_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            blm_pkg::REG_SAMPLE_COUNT:     count_ff <= csr_wdata[blm_pkg::CNT_W-1:0];
            blm_pkg::REG_FULL_MILLIVOLTS:  full_ff  <= csr_wdata[blm_pkg::MV_W-1:0];
            blm_pkg::REG_EMPTY_MILLIVOLTS: empty_ff <= csr_wdata[blm_pkg::MV_W-1:0];
            default: ;
         endcase
      end
   end

   // Batch accumulation; a zero count acts as one
   always_comb begin
      need       = (count_ff == '0) ? blm_pkg::CNT_W'(1) : count_ff;
      sum_in     = sum_ff + blm_pkg::SUM_W'(req_sample);
      taken_in   = taken_ff + 1'b1;
      batch_done = (taken_in == '0) || (taken_in >= need);
      avg_div    = {(taken_in == '0), taken_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         taken_ff <= '0;
      end else if (cmd.accept) begin
         sum_ff   <= batch_done ? '0 : sum_in;
         taken_ff <= batch_done ? '0 : taken_in;
      end
   end

   // Percent operands and special cases
   always_comb begin
      span     = full_ff - empty_ff;
      pct_num  = blm_pkg::PCT_NUM_W'(mv_ff - empty_ff) * blm_pkg::PCT_NUM_W'(blm_pkg::PERCENT_FULL);
      pct_zero = (full_ff <= empty_ff) || (mv_ff <= empty_ff);
   end

   // Divider operand select
   always_comb begin
      case (cmd.div_sel)
         blm_pkg::SEL_AVG: begin
            div_dividend = blm_pkg::DIV_W'(sum_in);
            div_divisor  = blm_pkg::MV_W'(avg_div);
         end
         blm_pkg::SEL_PCT: begin
            div_dividend = blm_pkg::DIV_W'(pct_num);
            div_divisor  = span;
         end
         blm_pkg::SEL_CMP: begin
            div_dividend = blm_pkg::DIV_W'({full_ff, 8'd0});
            div_divisor  = mv_ff;
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   blm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Clamp and saturate the two ratio results
   always_comb begin
      if (pct_zero) begin
         pct_in = '0;
      end else if (div_quotient > blm_pkg::DIV_W'(blm_pkg::PERCENT_FULL)) begin
         pct_in = blm_pkg::PERCENT_FULL;
      end else begin
         pct_in = div_quotient[blm_pkg::PCT_W-1:0];
      end
      if ((mv_ff == '0) || (|div_quotient[blm_pkg::DIV_W-1:blm_pkg::CMP_W])) begin
         cmp_in = blm_pkg::CMP_SATURATED;
      end else begin
         cmp_in = div_quotient[blm_pkg::CMP_W-1:0];
      end
   end

   // Millivolt scaling: avg * 13006 >> SAMPLE_BITS
   assign prod = blm_pkg::PROD_W'(avg_ff) * blm_pkg::PROD_W'(blm_pkg::MV_SCALE);

   // Intermediate and output payload registers
   always_ff @(posedge clock) begin
      if (cmd.avg_load) avg_ff <= div_quotient[blm_pkg::SUM_W-1:0];
      if (cmd.mv_load)  mv_ff  <= prod[blm_pkg::SAMPLE_BITS +: blm_pkg::MV_W];
      if (cmd.pct_load) pct_ff <= pct_in;
      if (cmd.cmp_load) cmp_ff <= cmp_in;
      if (cmd.out_load) begin
         rsp_mv_ff  <= mv_ff;
         rsp_pct_ff <= pct_ff;
         rsp_cmp_ff <= cmp_ff;
      end
   end

   assign status.batch_done     = batch_done;
   assign status.div_done       = div_done;
   assign rsp_battery_millivolts = rsp_mv_ff;
   assign rsp_charge_percent     = rsp_pct_ff;
   assign rsp_drive_compensation = rsp_cmp_ff;

endmodule

FILE: sv/blm_ctrl.sv
// Controller: sequences accumulation, the three divisions and the result beat.
`include "battery_level_monitor_top_defines.svh"

module blm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  blm_pkg::status_type   status,
   output blm_pkg::cmd_type      cmd
);

   blm_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.div_sel   = blm_pkg::SEL_AVG;
      req_ready     = 1'b0;
      case (state_ff)
         blm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.batch_done) begin
                  cmd.div_start = 1'b1;
                  state_in      = blm_pkg::ST_AVG;
               end
            end
         end
         blm_pkg::ST_AVG: begin
            if (status.div_done) begin
               cmd.avg_load = 1'b1;
               state_in     = blm_pkg::ST_SCALE;
            end
         end
         blm_pkg::ST_SCALE: begin
            cmd.mv_load = 1'b1;
            state_in    = blm_pkg::ST_PCT_GO;
         end
         blm_pkg::ST_PCT_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = blm_pkg::SEL_PCT;
            state_in      = blm_pkg::ST_PCT;
         end
         blm_pkg::ST_PCT: begin
            if (status.div_done) begin
               cmd.pct_load  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = blm_pkg::SEL_CMP;
               state_in      = blm_pkg::ST_CMP;
            end
         end
         blm_pkg::ST_CMP: begin
            if (status.div_done) begin
               cmd.cmp_load = 1'b1;
               state_in     = blm_pkg::ST_EMIT;
            end
         end
         blm_pkg::ST_EMIT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = blm_pkg::ST_IDLE;
            end
         end
         default: state_in = blm_pkg::ST_IDLE;
      endcase
   end

   // Output beat holding register
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Checks
   `BLM_ASSERT_NEXT(a_batch_starts_avg, cmd.accept && status.batch_done, state_ff == blm_pkg::ST_AVG)
   `BLM_ASSERT_NOW(a_div_done_in_div_state, status.div_done, (state_ff == blm_pkg::ST_AVG) || (state_ff == blm_pkg::ST_PCT) || (state_ff == blm_pkg::ST_CMP))
   `BLM_ASSERT_NOW(a_no_overwrite, cmd.out_load, !rsp_valid_ff || rsp_ready)
   `BLM_ASSERT_NEXT(a_load_shows_beat, cmd.out_load, rsp_valid_ff)

endmodule

FILE: sv/battery_level_monitor_top.sv
// Samples that do not close a batch are taken one per cycle while the controller is idle;
// a closing sample starts three 22-step passes of one shared divider plus load states
// that yield its result beat, and the next sample is taken only after that beat is loaded.
// A waiting result beat holds the input off only once the next batch closes behind it.
// Synchronous active-high reset restores the config defaults (10, 12600, 9900),
// empties the batch and drops any result not yet taken.
module battery_level_monitor_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [blm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [blm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [blm_pkg::SAMPLE_BITS-1:0]    req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [blm_pkg::MV_W-1:0]           rsp_battery_millivolts,
   output logic [blm_pkg::PCT_W-1:0]          rsp_charge_percent,
   output logic [blm_pkg::CMP_W-1:0]          rsp_drive_compensation
);

   blm_pkg::cmd_type    cmd;
   blm_pkg::status_type status;

   blm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   blm_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_sample             (req_sample),
      .rsp_battery_millivolts (rsp_battery_millivolts),
      .rsp_charge_percent     (rsp_charge_percent),
      .rsp_drive_compensation (rsp_drive_compensation)
   );

endmodule
